[design/lrs_pkg.sv]
package lrs_pkg;

  // field widths of the words on the channels
  localparam int ROW_IDX_W    = 4;
  localparam int COL_IDX_W    = 3;
  localparam int BIT_TICKS_W  = 10;
  localparam int HOLD_TICKS_W = 16;
  localparam int WAIT_W       = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // command codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIT_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 2'd1;

  // register reset values
  localparam logic [BIT_TICKS_W-1:0]  BIT_TICKS_RST  = 10'd20;
  localparam logic [HOLD_TICKS_W-1:0] HOLD_TICKS_RST = 16'd1000;

  // pin levels driven to the shift register chain
  typedef struct packed {
    logic oe_n;
    logic latch;
    logic clock;
    logic data;
  } pins_t;

  localparam pins_t PINS_RST = '{oe_n: 1'b1, latch: 1'b0, clock: 1'b0, data: 1'b0};

  // reload value for a wait of the given length, zero acts as one tick
  function automatic logic [WAIT_W-1:0] hold_for(input logic [WAIT_W-1:0] duration);
    logic [WAIT_W-1:0] r;
    r = (duration == '0) ? '0 : duration - WAIT_W'(1);
    return r;
  endfunction

endpackage

[design/lrs_if.sv]
// command channel: pixel writes and ticks
interface lrs_cmd_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [lrs_pkg::ROW_IDX_W-1:0] row_index;
  logic [lrs_pkg::COL_IDX_W-1:0] col_index;
  logic                          pixel_on;

  modport source (output valid, func, row_index, col_index, pixel_on, input ready);
  modport sink   (input valid, func, row_index, col_index, pixel_on, output ready);
endinterface

// result channel: pin levels after each tick
interface lrs_pins_if;
  logic valid;
  logic ready;
  logic data_pin;
  logic clock_pin;
  logic latch_pin;
  logic output_enable_n;

  modport source (output valid, data_pin, clock_pin, latch_pin, output_enable_n,
                  input ready);
  modport sink   (input valid, data_pin, clock_pin, latch_pin, output_enable_n,
                  output ready);
endinterface

// register write channel
interface lrs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lrs_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [lrs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

[design/lrs_frame_store.sv]
module lrs_frame_store #(
  parameter int ROWS = 16,
  parameter int COLS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [lrs_pkg::ROW_IDX_W-1:0] wr_row,
  input  logic [lrs_pkg::COL_IDX_W-1:0] wr_col,
  input  logic                          wr_pixel,
  input  logic [$clog2(ROWS)-1:0]       rd_row,
  output logic [COLS-1:0]               rd_bits
);
  import lrs_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

  logic [COLS-1:0] frame [ROWS];
  logic            in_range;
  logic [RW-1:0]   row_sel;
  logic [CW-1:0]   col_sel;

  // writes outside the matrix are dropped
  assign in_range = (32'(wr_row) < ROWS) && (32'(wr_col) < COLS);
  assign row_sel  = RW'(wr_row);
  assign col_sel  = CW'(wr_col);

  // pixel storage, dark after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        frame[r] <= '0;
      end
    end else if (wr_en && in_range) begin
      frame[row_sel][col_sel] <= wr_pixel;
    end
  end

  assign rd_bits = frame[rd_row];

endmodule

[design/lrs_scan_seq.sv]
module lrs_scan_seq #(
  parameter int ROWS = 16,
  parameter int COLS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             tick,
  input  logic [lrs_pkg::BIT_TICKS_W-1:0]  bit_ticks,
  input  logic [lrs_pkg::HOLD_TICKS_W-1:0] hold_ticks,
  input  logic [COLS-1:0]                  row_bits,
  output logic [$clog2(ROWS)-1:0]          scan_row,
  output lrs_pkg::pins_t                   pins_next
);
  import lrs_pkg::*;

  localparam int SRW = $clog2(ROWS);
  localparam int BPW = $clog2(COLS + ROWS);
  localparam int CW  = (COLS > 1) ? $clog2(COLS) : 1;

  localparam logic [2:0] PH_BLANK      = 3'd0;
  localparam logic [2:0] PH_LATCH_LOW  = 3'd1;
  localparam logic [2:0] PH_SET_DATA   = 3'd2;
  localparam logic [2:0] PH_CLOCK_HIGH = 3'd3;
  localparam logic [2:0] PH_CLOCK_LOW  = 3'd4;
  localparam logic [2:0] PH_LATCH_HIGH = 3'd5;
  localparam logic [2:0] PH_ENABLE     = 3'd6;

  logic [2:0]        phase, phase_next;
  logic [BPW-1:0]    bit_pos, bit_pos_next;
  logic [WAIT_W-1:0] wait_cnt, wait_cnt_next;
  logic [SRW-1:0]    scan_row_next;
  pins_t             pins;

  logic [WAIT_W-1:0] short_wait;
  logic [WAIT_W-1:0] long_wait;
  logic              is_column;
  logic [BPW-1:0]    sel_offset;
  logic              sel_bit;

  assign short_wait = hold_for(WAIT_W'(bit_ticks));
  assign long_wait  = hold_for(WAIT_W'(hold_ticks));
  assign is_column  = bit_pos < BPW'(COLS);

  // row-select bits go out most significant first, low for the scanned row
  assign sel_offset = bit_pos - BPW'(COLS);
  assign sel_bit    = sel_offset != (BPW'(ROWS - 1) - BPW'(scan_row));

  // one step of the pin sequence, or one tick of the current wait
  always_comb begin
    phase_next    = phase;
    bit_pos_next  = bit_pos;
    wait_cnt_next = wait_cnt;
    scan_row_next = scan_row;
    pins_next     = pins;
    if (wait_cnt != '0) begin
      wait_cnt_next = wait_cnt - WAIT_W'(1);
    end else begin
      case (phase)
        PH_BLANK: begin
          pins_next.oe_n = 1'b1;
          wait_cnt_next  = short_wait;
          phase_next     = PH_LATCH_LOW;
        end
        PH_LATCH_LOW: begin
          pins_next.latch = 1'b0;
          wait_cnt_next   = '0;
          bit_pos_next    = '0;
          phase_next      = PH_SET_DATA;
        end
        PH_SET_DATA: begin
          if (is_column) begin
            pins_next.data = row_bits[CW'(bit_pos)];
            wait_cnt_next  = short_wait;
          end else begin
            pins_next.data = sel_bit;
            wait_cnt_next  = '0;
          end
          phase_next = PH_CLOCK_HIGH;
        end
        PH_CLOCK_HIGH: begin
          pins_next.clock = 1'b1;
          wait_cnt_next   = short_wait;
          phase_next      = PH_CLOCK_LOW;
        end
        PH_CLOCK_LOW: begin
          pins_next.clock = 1'b0;
          wait_cnt_next   = (bit_pos == BPW'(COLS - 1)) ? short_wait : '0;
          if (bit_pos == BPW'(COLS + ROWS - 1)) begin
            bit_pos_next = '0;
            phase_next   = PH_LATCH_HIGH;
          end else begin
            bit_pos_next = bit_pos + BPW'(1);
            phase_next   = PH_SET_DATA;
          end
        end
        PH_LATCH_HIGH: begin
          pins_next.latch = 1'b1;
          wait_cnt_next   = short_wait;
          phase_next      = PH_ENABLE;
        end
        default: begin
          pins_next.oe_n = 1'b0;
          wait_cnt_next  = long_wait;
          scan_row_next  = (scan_row == SRW'(ROWS - 1)) ? '0 : scan_row + SRW'(1);
          phase_next     = PH_BLANK;
        end
      endcase
    end
  end

  // sequencer state, advanced once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_BLANK;
      bit_pos  <= '0;
      wait_cnt <= '0;
      scan_row <= '0;
      pins     <= PINS_RST;
    end else if (tick) begin
      phase    <= phase_next;
      bit_pos  <= bit_pos_next;
      wait_cnt <= wait_cnt_next;
      scan_row <= scan_row_next;
      pins     <= pins_next;
    end
  end

  // outputs are enabled only between the enable step and the next blank step
  assert property (@(posedge clk) disable iff (rst) !pins.oe_n |-> phase == PH_BLANK)
    else $error("outputs enabled outside the display hold");

  // the shift clock is high only while waiting for its falling edge
  assert property (@(posedge clk) disable iff (rst) pins.clock |-> phase == PH_CLOCK_LOW)
    else $error("shift clock high outside a bit shift");

  // the latch stays high from latch-high until the next row drops it
  assert property (@(posedge clk) disable iff (rst)
    pins.latch |-> (phase == PH_ENABLE || phase == PH_BLANK || phase == PH_LATCH_LOW))
    else $error("latch high during shifting");

endmodule

[design/led_matrix_row_scanner.sv]
// Row scanner for a one-bit LED matrix behind a chain of serial shift registers.
// pixel_cmd carries one word per command: func write stores pixel_on at
// (row_index, col_index), func tick advances the pin sequence by one step or one tick of its wait.
// Writes outside the matrix are dropped; a write gives no result word.
// pins carries one word per tick: the data, shift clock, latch and active-low
// output enable levels after that tick.
// cfg writes bit_ticks (index 0) and hold_ticks (index 1); it is always ready
// and other indexes are ignored. Write it only while no command is in flight.
// A command is registered at accept; a tick's result is registered in the result
// register when the tick leaves the command register.
// Throughput: one command per cycle unless a stalled pins receiver holds a tick,
// set by the combinational sequencer step between command and result register.
// A stalled pins receiver holds the result register; a write can still pass
// behind it, a further tick waits in the command register.
// Reset (synchronous) clears the frame store, starts the scan at row 0 in the
// blank step with outputs disabled, and restores the register defaults.
module led_matrix_row_scanner #(
  parameter int ROWS = 16,
  parameter int COLS = 8
) (
  input logic       clk,
  input logic       rst,
  lrs_cmd_if.sink   pixel_cmd,
  lrs_pins_if.source pins,
  lrs_cfg_if.sink   cfg
);
  import lrs_pkg::*;

  localparam int SRW = $clog2(ROWS);

  logic [BIT_TICKS_W-1:0]  bit_ticks;
  logic [HOLD_TICKS_W-1:0] hold_ticks;

  logic                 s0_valid;
  logic                 s0_func;
  logic [ROW_IDX_W-1:0] s0_row;
  logic [COL_IDX_W-1:0] s0_col;
  logic                 s0_pixel;
  logic                 s0_go;
  logic                 out_free;
  logic                 tick;
  logic                 cmd_fire;

  logic [SRW-1:0]  scan_row;
  logic [COLS-1:0] row_bits;
  pins_t           pins_next;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks  <= BIT_TICKS_RST;
      hold_ticks <= HOLD_TICKS_RST;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_BIT_TICKS:  bit_ticks  <= cfg.data[BIT_TICKS_W-1:0];
        REG_HOLD_TICKS: hold_ticks <= cfg.data[HOLD_TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // command register; a write never needs the result register
  assign out_free        = !pins.valid || pins.ready;
  assign s0_go           = s0_valid && (s0_func == FUNC_WRITE || out_free);
  assign pixel_cmd.ready = !s0_valid || s0_go;
  assign cmd_fire        = pixel_cmd.valid && pixel_cmd.ready;
  assign tick            = s0_go && s0_func == FUNC_TICK;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (pixel_cmd.ready) begin
      s0_valid <= pixel_cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s0_func  <= pixel_cmd.func;
      s0_row   <= pixel_cmd.row_index;
      s0_col   <= pixel_cmd.col_index;
      s0_pixel <= pixel_cmd.pixel_on;
    end
  end

  lrs_frame_store #(.ROWS(ROWS), .COLS(COLS)) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (s0_go && s0_func == FUNC_WRITE),
    .wr_row   (s0_row),
    .wr_col   (s0_col),
    .wr_pixel (s0_pixel),
    .rd_row   (scan_row),
    .rd_bits  (row_bits)
  );

  lrs_scan_seq #(.ROWS(ROWS), .COLS(COLS)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .bit_ticks  (bit_ticks),
    .hold_ticks (hold_ticks),
    .row_bits   (row_bits),
    .scan_row   (scan_row),
    .pins_next  (pins_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pins.valid <= 1'b0;
    end else if (tick) begin
      pins.valid <= 1'b1;
    end else if (pins.ready) begin
      pins.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      pins.data_pin        <= pins_next.data;
      pins.clock_pin       <= pins_next.clock;
      pins.latch_pin       <= pins_next.latch;
      pins.output_enable_n <= pins_next.oe_n;
    end
  end

  // every tick leaves a result word behind
  assert property (@(posedge clk) disable iff (rst) tick |=> pins.valid)
    else $error("tick without a result word");

  // a write passing an empty result register creates no word
  assert property (@(posedge clk) disable iff (rst)
    (s0_go && s0_func == FUNC_WRITE && !pins.valid) |=> !pins.valid)
    else $error("write produced a result word");

  // a blocked command stays in its register unchanged
  assert property (@(posedge clk) disable iff (rst)
    (s0_valid && !s0_go) |=> (s0_valid && $stable(s0_func) && $stable(s0_row)))
    else $error("blocked command lost");

endmodule
